[design/spd_pkg.sv]
// shared types and constants for the stable priority deque
// no dependencies
`timescale 1ns / 1ps

package spd_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int ID_W          = 16;
   localparam int PRIO_W        = 8;
   localparam int COUNT_W       = 5;

   typedef enum logic [1:0] {
      ACT_INSERT    = 2'd0,
      ACT_POP_FRONT = 2'd1,
      ACT_POP_REAR  = 2'd2,
      ACT_SEARCH    = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_FULL      = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [PRIO_W-1:0] prio;
   } entry_type;

   typedef struct packed {
      status_type         status;
      logic [ID_W-1:0]    id;
      logic [PRIO_W-1:0]  prio;
      logic [COUNT_W-1:0] count;
   } result_type;

endpackage

[design/spd_slot_ram.sv]
// slot memory: one write port, one read port, registered read data
// depends on spd_pkg
`timescale 1ns / 1ps

module spd_slot_ram #(
   parameter int DEPTH = spd_pkg::DEPTH_DEFAULT,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  spd_pkg::entry_type  wr_data,
   input  logic                rd_en,
   input  logic [AW-1:0]       rd_addr,
   output spd_pkg::entry_type  rd_data
);
   import spd_pkg::*;

   entry_type mem_ff [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/spd_ctrl.sv]
// request sequencer: walks the circular slot memory one entry per read/eval pair
// depends on spd_pkg and drives spd_slot_ram
`timescale 1ns / 1ps

module spd_ctrl #(
   parameter int DEPTH = spd_pkg::DEPTH_DEFAULT,
   parameter int AW    = $clog2(DEPTH),
   parameter int CW    = $clog2(DEPTH + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  spd_pkg::action_type           req_action,
   input  logic [spd_pkg::ID_W-1:0]      req_id,
   input  logic [spd_pkg::PRIO_W-1:0]    req_prio,
   output logic                          res_valid,
   input  logic                          res_free,
   output spd_pkg::result_type           res,
   output logic                          wr_en,
   output logic [AW-1:0]                 wr_addr,
   output spd_pkg::entry_type            wr_data,
   output logic                          rd_en,
   output logic [AW-1:0]                 rd_addr,
   input  spd_pkg::entry_type            rd_data
);
   import spd_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_EVAL,
      S_PUT,
      S_DONE
   } state_type;

   state_type         state_ff;
   action_type        act_ff;
   logic [ID_W-1:0]   id_ff;
   logic [PRIO_W-1:0] prio_ff;
   logic [AW-1:0]     idx_ff;
   logic [AW-1:0]     head_ff;
   logic [CW-1:0]     count_ff;
   status_type        status_ff;
   entry_type         found_ff;

   // logical position to physical slot, head-relative with one wrap
   function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                          input logic [CW-1:0] pos);
      logic [AW:0] sum;
      begin
         sum = {1'b0, head} + (AW+1)'(pos);
         if (sum >= (AW+1)'(DEPTH)) begin
            sum = sum - (AW+1)'(DEPTH);
         end
         phys = sum[AW-1:0];
      end
   endfunction

   logic [CW-1:0] idx_ext;
   logic [CW-1:0] idx_next;
   logic [CW-1:0] count_m1;
   logic          accept;

   assign idx_ext  = CW'(idx_ff);
   assign idx_next = idx_ext + 1'b1;
   assign count_m1 = count_ff - 1'b1;
   assign accept   = req_valid && req_ready;

   assign req_ready = (state_ff == S_IDLE);
   assign rd_en     = (state_ff == S_READ);
   assign rd_addr   = phys(head_ff, idx_ext);

   // writes happen only in eval and put; reads only in read, so no overlap
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = phys(head_ff, idx_next);
      wr_data = '{id: id_ff, prio: prio_ff};
      if (state_ff == S_EVAL && act_ff == ACT_INSERT) begin
         wr_en = 1'b1;
         if (rd_data.prio < prio_ff) begin
            wr_data = rd_data;
         end
      end else if (state_ff == S_PUT) begin
         wr_en   = 1'b1;
         wr_addr = head_ff;
      end
   end

   assign res_valid = (state_ff == S_DONE);
   assign res       = '{status: status_ff, id: found_ff.id, prio: found_ff.prio,
                        count: COUNT_W'(count_ff)};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  act_ff    <= req_action;
                  id_ff     <= req_id;
                  prio_ff   <= req_prio;
                  status_ff <= ST_OK;
                  found_ff  <= '0;
                  case (req_action)
                     ACT_INSERT: begin
                        idx_ff <= AW'(count_m1);
                        if (count_ff == CW'(DEPTH)) begin
                           status_ff <= ST_FULL;
                           state_ff  <= S_DONE;
                        end else if (count_ff == '0) begin
                           state_ff <= S_PUT;
                        end else begin
                           state_ff <= S_READ;
                        end
                     end
                     ACT_POP_FRONT, ACT_POP_REAR: begin
                        idx_ff <= (req_action == ACT_POP_FRONT) ? '0 : AW'(count_m1);
                        if (count_ff == '0) begin
                           status_ff <= ST_EMPTY;
                           state_ff  <= S_DONE;
                        end else begin
                           state_ff <= S_READ;
                        end
                     end
                     default: begin
                        idx_ff <= '0;
                        if (count_ff == '0) begin
                           status_ff <= ST_NOT_FOUND;
                           state_ff  <= S_DONE;
                        end else begin
                           state_ff <= S_READ;
                        end
                     end
                  endcase
               end
            end
            S_READ: begin
               state_ff <= S_EVAL;
            end
            S_EVAL: begin
               case (act_ff)
                  ACT_INSERT: begin
                     // scan from the rear, shifting lower priorities back by one
                     if (rd_data.prio >= prio_ff) begin
                        count_ff <= count_ff + 1'b1;
                        state_ff <= S_DONE;
                     end else if (idx_ff == '0) begin
                        state_ff <= S_PUT;
                     end else begin
                        idx_ff   <= idx_ff - 1'b1;
                        state_ff <= S_READ;
                     end
                  end
                  ACT_POP_FRONT: begin
                     found_ff <= rd_data;
                     count_ff <= count_m1;
                     head_ff  <= (head_ff == AW'(DEPTH - 1)) ? '0 : head_ff + 1'b1;
                     state_ff <= S_DONE;
                  end
                  ACT_POP_REAR: begin
                     found_ff <= rd_data;
                     count_ff <= count_m1;
                     state_ff <= S_DONE;
                  end
                  default: begin
                     if (rd_data.id == id_ff) begin
                        found_ff <= rd_data;
                        state_ff <= S_DONE;
                     end else if (idx_next == count_ff) begin
                        status_ff <= ST_NOT_FOUND;
                        state_ff  <= S_DONE;
                     end else begin
                        idx_ff   <= idx_ff + 1'b1;
                        state_ff <= S_READ;
                     end
                  end
               endcase
            end
            S_PUT: begin
               count_ff <= count_ff + 1'b1;
               state_ff <= S_DONE;
            end
            S_DONE: begin
               if (res_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

[design/stable_priority_deque_core.sv]
// Stable priority deque of up to DEPTH jobs kept in descending priority order,
// equal priorities in arrival order. Jobs live in one single-port-read slot
// memory used as a circular buffer, so remove-front and remove-rear each need
// only a single memory read. Insert walks from the rear, one entry per memory
// read followed by a compare and shift-write, and search walks from the front
// the same way, one entry per read and compare. One request is in work at a
// time; a finished result sits in the output register while the next request
// is taken. No clearing pass after reset.
// depends on spd_pkg, spd_ctrl, spd_slot_ram
`timescale 1ns / 1ps

module stable_priority_deque_core #(
   parameter int DEPTH = spd_pkg::DEPTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [1:0]                     req_action,
   input  logic [spd_pkg::ID_W-1:0]       req_job_id,
   input  logic [spd_pkg::PRIO_W-1:0]     req_job_priority,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [1:0]                     rsp_status,
   output logic [spd_pkg::ID_W-1:0]       rsp_found_id,
   output logic [spd_pkg::PRIO_W-1:0]     rsp_found_priority,
   output logic [spd_pkg::COUNT_W-1:0]    rsp_entry_count
);
   import spd_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   entry_type     wr_data;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   entry_type     rd_data;
   logic          res_valid;
   logic          res_free;
   result_type    res;

   logic          rsp_valid_ff;
   result_type    rsp_ff;

   assign res_free = !rsp_valid_ff || rsp_ready;

   spd_ctrl #(
      .DEPTH (DEPTH),
      .AW    (AW),
      .CW    (CW)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_action (action_type'(req_action)),
      .req_id     (req_job_id),
      .req_prio   (req_job_priority),
      .res_valid  (res_valid),
      .res_free   (res_free),
      .res        (res),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data)
   );

   spd_slot_ram #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // output register, loaded when the sequencer finishes and the slot is free
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_valid && res_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_free) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_ff.status;
   assign rsp_found_id       = rsp_ff.id;
   assign rsp_found_priority = rsp_ff.prio;
   assign rsp_entry_count    = rsp_ff.count;

endmodule

[tb/tb_stable_priority_deque_core.sv]
// testbench for stable_priority_deque_core: directed and random request traffic
// with random idling on both channels, checked against a behavioral deque model
// depends on spd_pkg and stable_priority_deque_core
`timescale 1ns / 1ps

module tb_stable_priority_deque_core;
   import spd_pkg::*;

   localparam int QUEUE_DEPTH  = DEPTH_DEFAULT;
   localparam int RANDOM_ITEMS = 800;
   localparam int DRAIN_CYCLES = 4 * QUEUE_DEPTH + 20;
   localparam int CYCLE_LIMIT  = 400000;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [1:0]          req_action = ACT_INSERT;
   logic [ID_W-1:0]     req_job_id = '0;
   logic [PRIO_W-1:0]   req_job_priority = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [1:0]          rsp_status;
   logic [ID_W-1:0]     rsp_found_id;
   logic [PRIO_W-1:0]   rsp_found_priority;
   logic [COUNT_W-1:0]  rsp_entry_count;

   // behavioral copy of the deque, front at index 0
   entry_type  held_jobs [QUEUE_DEPTH];
   int         held_count = 0;
   result_type expected_responses [$];

   int  cycle_count = 0;
   int  error_count = 0;
   int  checked_count = 0;
   int  action_counts [4] = '{0, 0, 0, 0};
   int  full_hits = 0;
   int  empty_hits = 0;
   int  miss_hits = 0;
   int  search_hits = 0;
   int  rsp_stall_left = 0;
   bit  gaps_enabled = 1'b1;

   stable_priority_deque_core #(
      .DEPTH (QUEUE_DEPTH)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_action         (req_action),
      .req_job_id         (req_job_id),
      .req_job_priority   (req_job_priority),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_found_id       (rsp_found_id),
      .rsp_found_priority (rsp_found_priority),
      .rsp_entry_count    (rsp_entry_count)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, expected_responses.size());
         $display("[stable_priority_deque_core] ERROR");
         $finish;
      end
   end

   // mostly short idle stretches, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60)      return 0;
      else if (r < 90) return $urandom_range(1, 3);
      else if (r < 98) return $urandom_range(4, 10);
      else             return $urandom_range(20, 40);
   endfunction

   function automatic result_type predict_deque_response(action_type act,
                                                         logic [ID_W-1:0] id,
                                                         logic [PRIO_W-1:0] prio);
      result_type r;
      int         pos;
      int         i;
      r        = '0;
      r.status = ST_OK;
      case (act)
         ACT_INSERT: begin
            if (held_count >= QUEUE_DEPTH) begin
               r.status = ST_FULL;
               full_hits++;
            end else begin
               // stays behind every entry of equal or higher priority
               pos = 0;
               while (pos < held_count && held_jobs[pos].prio >= prio) pos++;
               for (i = held_count; i > pos; i--) held_jobs[i] = held_jobs[i-1];
               held_jobs[pos].id   = id;
               held_jobs[pos].prio = prio;
               held_count++;
            end
         end
         ACT_POP_FRONT: begin
            if (held_count == 0) begin
               r.status = ST_EMPTY;
               empty_hits++;
            end else begin
               r.id   = held_jobs[0].id;
               r.prio = held_jobs[0].prio;
               for (i = 1; i < held_count; i++) held_jobs[i-1] = held_jobs[i];
               held_count--;
            end
         end
         ACT_POP_REAR: begin
            if (held_count == 0) begin
               r.status = ST_EMPTY;
               empty_hits++;
            end else begin
               held_count--;
               r.id   = held_jobs[held_count].id;
               r.prio = held_jobs[held_count].prio;
            end
         end
         default: begin
            r.status = ST_NOT_FOUND;
            for (i = 0; i < held_count; i++) begin
               if (r.status == ST_NOT_FOUND && held_jobs[i].id == id) begin
                  r.status = ST_OK;
                  r.id     = held_jobs[i].id;
                  r.prio   = held_jobs[i].prio;
               end
            end
            if (r.status == ST_OK) search_hits++;
            else miss_hits++;
         end
      endcase
      r.count = COUNT_W'(held_count);
      return r;
   endfunction

   task automatic send_request(action_type act, logic [ID_W-1:0] id,
                               logic [PRIO_W-1:0] prio);
      int gap;
      gap = gaps_enabled ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_action       <= act;
      req_job_id       <= id;
      req_job_priority <= prio;
      do @(posedge clock); while (!req_ready);
      expected_responses.push_back(predict_deque_response(act, id, prio));
      action_counts[act]++;
   endtask

   // response side stalls
   always @(posedge clock) begin
      if (rsp_stall_left > 0) begin
         rsp_ready      <= 1'b0;
         rsp_stall_left <= rsp_stall_left - 1;
      end else if (gaps_enabled && $urandom_range(0, 3) == 0) begin
         rsp_ready      <= 1'b0;
         rsp_stall_left <= pick_gap();
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // response checker
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_responses.size() == 0) begin
            $error("response with nothing outstanding: status %0d id %0h prio %0h",
                   rsp_status, rsp_found_id, rsp_found_priority);
            error_count++;
         end else begin
            want = expected_responses.pop_front();
            checked_count++;
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               error_count++;
            end
            if (rsp_found_id !== want.id) begin
               $error("found_id: expected %0h, got %0h", want.id, rsp_found_id);
               error_count++;
            end
            if (rsp_found_priority !== want.prio) begin
               $error("found_priority: expected %0h, got %0h",
                      want.prio, rsp_found_priority);
               error_count++;
            end
            if (rsp_entry_count !== want.count) begin
               $error("entry_count: expected %0d, got %0d", want.count, rsp_entry_count);
               error_count++;
            end
         end
      end
   end

   task automatic test_empty_queue();
      send_request(ACT_POP_FRONT, 16'h0000, 8'h00);
      send_request(ACT_POP_REAR, 16'hFFFF, 8'hFF);
      send_request(ACT_SEARCH, 16'h0000, 8'h00);
   endtask

   task automatic test_insert_order();
      send_request(ACT_INSERT, 16'hFFFF, 8'h00);
      send_request(ACT_INSERT, 16'h0000, 8'hFF);
      send_request(ACT_INSERT, 16'h1234, 8'h80);
      send_request(ACT_INSERT, 16'h1235, 8'h80);
      // tie with the head must land behind it
      send_request(ACT_INSERT, 16'hA5A5, 8'hFF);
   endtask

   task automatic test_search();
      send_request(ACT_SEARCH, 16'h1235, 8'h00);
      send_request(ACT_SEARCH, 16'h5A5A, 8'h00);
      send_request(ACT_SEARCH, 16'hFFFF, 8'h00);
   endtask

   task automatic test_pop_both_ends();
      send_request(ACT_POP_FRONT, 16'h0000, 8'h00);
      send_request(ACT_POP_REAR, 16'h0000, 8'h00);
   endtask

   task automatic test_fill_to_full();
      int n;
      n = 0;
      // duplicate id at low priority, search must still return the front one
      send_request(ACT_INSERT, 16'h1234, 8'h01);
      while (held_count < QUEUE_DEPTH) begin
         send_request(ACT_INSERT, 16'h0100 + ID_W'(n), PRIO_W'(8'h80 - 8'(n % 3)));
         n++;
      end
      send_request(ACT_INSERT, 16'h7FFF, 8'hFF);
      send_request(ACT_SEARCH, 16'h1234, 8'h00);
   endtask

   function automatic logic [ID_W-1:0] pick_job_id();
      case ($urandom_range(0, 3))
         0, 1:    return 16'h0010 + ID_W'($urandom_range(0, 7));
         2:       return (held_count > 0) ?
                         held_jobs[$urandom_range(0, held_count - 1)].id :
                         ID_W'($urandom());
         default: return ID_W'($urandom());
      endcase
   endfunction

   function automatic logic [PRIO_W-1:0] pick_priority();
      case ($urandom_range(0, 3))
         0: begin
            case ($urandom_range(0, 3))
               0:       return 8'h00;
               1:       return 8'hFF;
               2:       return 8'h40;
               default: return 8'h41;
            endcase
         end
         1:       return PRIO_W'($urandom_range(100, 103));
         default: return PRIO_W'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic test_random_traffic();
      int n;
      int r;
      bit filling;
      filling = 1'b1;
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         // every third block of 100 requests runs without idling
         if (n % 100 == 0) gaps_enabled = ((n / 100) % 3) != 2;
         if (held_count == QUEUE_DEPTH && $urandom_range(0, 9) < 7) filling = 1'b0;
         else if (held_count == 0 && $urandom_range(0, 9) < 7) filling = 1'b1;
         else if ($urandom_range(0, 99) < 3) filling = !filling;
         r = $urandom_range(0, 99);
         if (r < 15)
            send_request(ACT_SEARCH, pick_job_id(), PRIO_W'($urandom()));
         else if (r < (filling ? 75 : 35))
            send_request(ACT_INSERT, pick_job_id(), pick_priority());
         else if ($urandom_range(0, 1) == 0)
            send_request(ACT_POP_FRONT, ID_W'($urandom()), PRIO_W'($urandom()));
         else
            send_request(ACT_POP_REAR, ID_W'($urandom()), PRIO_W'($urandom()));
      end
   endtask

   task automatic wait_for_drain();
      req_valid    <= 1'b0;
      gaps_enabled = 1'b0;
      while (expected_responses.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_empty_queue();
      test_insert_order();
      test_search();
      test_pop_both_ends();
      test_fill_to_full();
      test_random_traffic();
      wait_for_drain();
      $display("sent %0d inserts, %0d front pops, %0d rear pops, %0d searches; %0d checked",
               action_counts[ACT_INSERT], action_counts[ACT_POP_FRONT],
               action_counts[ACT_POP_REAR], action_counts[ACT_SEARCH], checked_count);
      $display("full drops %0d, empty pops %0d, search hits %0d, search misses %0d",
               full_hits, empty_hits, search_hits, miss_hits);
      if (error_count == 0) begin
         $display("[stable_priority_deque_core] OK");
      end else begin
         $display("[stable_priority_deque_core] ERROR");
      end
      $finish;
   end

endmodule
